@@ sv/limited_double_integrator_assert.svh @@
// Assertion macros shared by the limited double integrator RTL.
// Simulation builds get concurrent assertions; synthesis builds get empty bodies.
`ifndef LIMITED_DOUBLE_INTEGRATOR_ASSERT_SVH
`define LIMITED_DOUBLE_INTEGRATOR_ASSERT_SVH

`ifndef SYNTHESIS
`define LMDI_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`else
`define LMDI_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`endif

`ifndef SYNTHESIS
`define LMDI_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define LMDI_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

@@ sv/lmdi_pkg.sv @@
// Package for the limited double integrator: widths, types, codes and
// saturation helpers. No dependencies.
`timescale 1ns / 1ps

package lmdi_pkg;

  localparam int DATA_W = 32;
  localparam int PER_W  = 16;
  localparam int INV_W  = 32;
  localparam int ADDR_W = 5;
  localparam int DIFF_W = DATA_W + 1;
  localparam int OPB_W  = PER_W + 1;
  localparam int PROD_W = DIFF_W + OPB_W;
  localparam int LO_W   = PROD_W - PER_W;
  localparam int SUM_W  = PROD_W + 1;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic signed [OPB_W-1:0]  opb_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [LO_W-1:0]   lo_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  localparam data_t DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam data_t DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  localparam logic [PER_W-1:0] RST_TICK_PERIOD = PER_W'(66);
  localparam logic [INV_W-1:0] RST_INV_PERIOD  = INV_W'(65536000);

  typedef enum logic [2:0] {
    RI_POS_MIN,
    RI_POS_MAX,
    RI_VEL_MIN,
    RI_VEL_MAX,
    RI_ACC_MIN,
    RI_ACC_MAX,
    RI_TICK_PERIOD,
    RI_INV_PERIOD
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_A,
    S_VEL,
    S_MUL_V,
    S_POS,
    S_DIFF,
    S_MUL_LO,
    S_MUL_HI,
    S_FIN
  } state_t;

  typedef enum logic [1:0] {
    MS_ACC_PER,
    MS_VEL_PER,
    MS_DIFF_LO,
    MS_DIFF_HI
  } mul_sel_t;

  typedef struct packed {
    data_t               pos_min;
    data_t               pos_max;
    data_t               vel_min;
    data_t               vel_max;
    data_t               acc_min;
    data_t               acc_max;
    logic [PER_W-1:0]    tick_period;
    logic [INV_W-1:0]    inv_period;
  } cfg_t;

  typedef struct packed {
    logic     accept;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     vel_ld;
    logic     pos_ld;
    logic     diff_ld;
    logic     lo_ld;
    logic     commit;
  } ctrl_t;

  function automatic sum_t sext_data(data_t x);
    return {{(SUM_W-DATA_W){x[DATA_W-1]}}, x};
  endfunction

  function automatic sum_t sext_lo(lo_t x);
    return {{(SUM_W-LO_W){x[LO_W-1]}}, x};
  endfunction

  // Saturate to the signed data range: the value fits when all bits from
  // the data sign bit upward agree.
  function automatic data_t sat_data(sum_t x);
    logic [SUM_W-DATA_W:0] top;
    top = x[SUM_W-1:DATA_W-1];
    if ((&top) || !(|top)) begin
      return x[DATA_W-1:0];
    end else if (x[SUM_W-1]) begin
      return DATA_MIN;
    end else begin
      return DATA_MAX;
    end
  endfunction

  // Lower bound first, then upper bound, so the upper bound wins when crossed.
  function automatic data_t clamp_lim(data_t x, data_t lo, data_t hi);
    data_t t;
    t = (x < lo) ? lo : x;
    return (t > hi) ? hi : t;
  endfunction

endpackage

@@ sv/lmdi_cfg.sv @@
// Configuration register file for the limited double integrator, APB-style.
// Depends on lmdi_pkg.
`timescale 1ns / 1ps

module lmdi_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [lmdi_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready,
  output lmdi_pkg::cfg_t              cfg
);

  lmdi_pkg::cfg_t     cfg_r;
  lmdi_pkg::reg_idx_t idx;
  logic               wr_en;

  assign cfg_pready = 1'b1;
  assign idx        = lmdi_pkg::reg_idx_t'(cfg_paddr[4:2]);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pos_min     <= lmdi_pkg::DATA_MIN;
      cfg_r.pos_max     <= lmdi_pkg::DATA_MAX;
      cfg_r.vel_min     <= lmdi_pkg::DATA_MIN;
      cfg_r.vel_max     <= lmdi_pkg::DATA_MAX;
      cfg_r.acc_min     <= lmdi_pkg::DATA_MIN;
      cfg_r.acc_max     <= lmdi_pkg::DATA_MAX;
      cfg_r.tick_period <= lmdi_pkg::RST_TICK_PERIOD;
      cfg_r.inv_period  <= lmdi_pkg::RST_INV_PERIOD;
    end else if (wr_en) begin
      unique case (idx)
        lmdi_pkg::RI_POS_MIN:     cfg_r.pos_min     <= cfg_pwdata;
        lmdi_pkg::RI_POS_MAX:     cfg_r.pos_max     <= cfg_pwdata;
        lmdi_pkg::RI_VEL_MIN:     cfg_r.vel_min     <= cfg_pwdata;
        lmdi_pkg::RI_VEL_MAX:     cfg_r.vel_max     <= cfg_pwdata;
        lmdi_pkg::RI_ACC_MIN:     cfg_r.acc_min     <= cfg_pwdata;
        lmdi_pkg::RI_ACC_MAX:     cfg_r.acc_max     <= cfg_pwdata;
        lmdi_pkg::RI_TICK_PERIOD: cfg_r.tick_period <= cfg_pwdata[lmdi_pkg::PER_W-1:0];
        lmdi_pkg::RI_INV_PERIOD:  cfg_r.inv_period  <= cfg_pwdata;
        default:                  cfg_r.inv_period  <= cfg_r.inv_period;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      lmdi_pkg::RI_POS_MIN:     cfg_prdata = cfg_r.pos_min;
      lmdi_pkg::RI_POS_MAX:     cfg_prdata = cfg_r.pos_max;
      lmdi_pkg::RI_VEL_MIN:     cfg_prdata = cfg_r.vel_min;
      lmdi_pkg::RI_VEL_MAX:     cfg_prdata = cfg_r.vel_max;
      lmdi_pkg::RI_ACC_MIN:     cfg_prdata = cfg_r.acc_min;
      lmdi_pkg::RI_ACC_MAX:     cfg_prdata = cfg_r.acc_max;
      lmdi_pkg::RI_TICK_PERIOD: cfg_prdata = {{(32-lmdi_pkg::PER_W){1'b0}}, cfg_r.tick_period};
      lmdi_pkg::RI_INV_PERIOD:  cfg_prdata = cfg_r.inv_period;
      default:                  cfg_prdata = '0;
    endcase
  end

endmodule

@@ sv/lmdi_mul.sv @@
// Shared signed 33 x 17 multiplier with a registered product.
// Depends on lmdi_pkg.
`timescale 1ns / 1ps

module lmdi_mul (
  input  logic                clk,
  input  logic                en,
  input  lmdi_pkg::diff_t     op_a,
  input  lmdi_pkg::opb_t      op_b,
  output lmdi_pkg::prod_t     prod_r
);

  lmdi_pkg::prod_t prod_nxt;

  assign prod_nxt = op_a * op_b;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

@@ sv/lmdi_ctrl.sv @@
// Sequencer for the limited double integrator: steps one item through the
// shared multiplier and the saturating adders. Depends on lmdi_pkg.
`timescale 1ns / 1ps

module lmdi_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  input  logic            in_clear,
  input  logic            out_busy,
  output logic            in_tready,
  output lmdi_pkg::ctrl_t ctrl
);

  lmdi_pkg::state_t state_r;
  lmdi_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lmdi_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lmdi_pkg::S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = in_clear ? lmdi_pkg::S_FIN : lmdi_pkg::S_MUL_A;
        end
      end
      lmdi_pkg::S_MUL_A:  state_nxt = lmdi_pkg::S_VEL;
      lmdi_pkg::S_VEL:    state_nxt = lmdi_pkg::S_MUL_V;
      lmdi_pkg::S_MUL_V:  state_nxt = lmdi_pkg::S_POS;
      lmdi_pkg::S_POS:    state_nxt = lmdi_pkg::S_DIFF;
      lmdi_pkg::S_DIFF:   state_nxt = lmdi_pkg::S_MUL_LO;
      lmdi_pkg::S_MUL_LO: state_nxt = lmdi_pkg::S_MUL_HI;
      lmdi_pkg::S_MUL_HI: state_nxt = lmdi_pkg::S_FIN;
      lmdi_pkg::S_FIN: begin
        if (!out_busy) begin
          state_nxt = lmdi_pkg::S_IDLE;
        end
      end
      default: state_nxt = lmdi_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_tready    = 1'b0;
    ctrl         = '0;
    ctrl.mul_sel = lmdi_pkg::MS_ACC_PER;
    unique case (state_r)
      lmdi_pkg::S_IDLE: begin
        in_tready   = 1'b1;
        ctrl.accept = in_tvalid;
      end
      lmdi_pkg::S_MUL_A: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = lmdi_pkg::MS_ACC_PER;
      end
      lmdi_pkg::S_VEL:   ctrl.vel_ld = 1'b1;
      lmdi_pkg::S_MUL_V: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = lmdi_pkg::MS_VEL_PER;
      end
      lmdi_pkg::S_POS:   ctrl.pos_ld = 1'b1;
      lmdi_pkg::S_DIFF:  ctrl.diff_ld = 1'b1;
      lmdi_pkg::S_MUL_LO: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = lmdi_pkg::MS_DIFF_LO;
      end
      lmdi_pkg::S_MUL_HI: begin
        ctrl.lo_ld   = 1'b1;
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = lmdi_pkg::MS_DIFF_HI;
      end
      lmdi_pkg::S_FIN:   ctrl.commit = !out_busy;
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

@@ sv/limited_double_integrator.sv @@
// Limited double integrator, top level: stream ports, datapath registers
// and output register. Depends on lmdi_pkg, lmdi_cfg, lmdi_mul, lmdi_ctrl.
//
// Usage:
//   Each request on the in_ channel is one control tick. in_tuser[0] is the
//   command (0 integrate, 1 clear) and in_tdata the requested acceleration.
//   Each request yields exactly one result on the out_ channel: position,
//   velocity and applied acceleration, all signed Q16.16.
//   An integrate request runs through S_MUL_A, S_VEL, S_MUL_V, S_POS, S_DIFF,
//   S_MUL_LO, S_MUL_HI and S_FIN from acceptance to out_tvalid; the steps are
//   three uses of one 33 x 17 multiplier (acceleration times period, velocity
//   times period, position change times the reciprocal period in two halves)
//   with a saturating add after each. A clear goes straight to S_FIN. While a
//   request is in progress in_tready stays low; no new request overlaps it.
//   A finished result sits in an output register, and the next request is
//   accepted while it waits. If the receiver stalls, the following result
//   holds in its last step until the register frees up.
//   Reset is synchronous and active low; it zeroes position and velocity and
//   loads the documented register defaults. Write configuration only while
//   no request is in progress.
`timescale 1ns / 1ps
`include "limited_double_integrator_assert.svh"

module limited_double_integrator (
  input  logic                        clk,
  input  logic                        rst_n,
  // APB-style configuration port
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [lmdi_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready,
  // Input stream
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [31:0]                 in_tdata,   // [31:0] accel_request
  input  logic [0:0]                  in_tuser,   // [0] command
  // Result stream
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [95:0]                 out_tdata   // [31:0] position_out,
                                                  // [63:32] velocity_out,
                                                  // [95:64] accel_applied
);

  lmdi_pkg::cfg_t   cfg;
  lmdi_pkg::ctrl_t  ctrl;
  lmdi_pkg::diff_t  op_a;
  lmdi_pkg::opb_t   op_b;
  lmdi_pkg::prod_t  prod_r;

  logic             clr_r;
  lmdi_pkg::data_t  acc_r;
  lmdi_pkg::data_t  vel_work_r;
  lmdi_pkg::data_t  pos_new_r;
  lmdi_pkg::diff_t  diff_r;
  lmdi_pkg::lo_t    lo_r;
  lmdi_pkg::data_t  pos_reg_r;
  lmdi_pkg::data_t  vel_reg_r;
  lmdi_pkg::data_t  new_vel;

  logic             out_valid_r;
  lmdi_pkg::data_t  out_pos_r;
  lmdi_pkg::data_t  out_vel_r;
  lmdi_pkg::data_t  out_acc_r;
  logic             out_busy;

  lmdi_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  lmdi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_clear  (in_tuser[0]),
    .out_busy  (out_busy),
    .in_tready (in_tready),
    .ctrl      (ctrl)
  );

  lmdi_mul u_mul (
    .clk    (clk),
    .en     (ctrl.mul_en),
    .op_a   (op_a),
    .op_b   (op_b),
    .prod_r (prod_r)
  );

  assign out_busy = out_valid_r && !out_tready;

  // The reciprocal period is split into two 16-bit halves; the high-half
  // product lines up with the floored low-half product after the shift.
  always_comb begin
    case (ctrl.mul_sel)
      lmdi_pkg::MS_ACC_PER: begin
        op_a = {acc_r[lmdi_pkg::DATA_W-1], acc_r};
        op_b = {1'b0, cfg.tick_period};
      end
      lmdi_pkg::MS_VEL_PER: begin
        op_a = {vel_work_r[lmdi_pkg::DATA_W-1], vel_work_r};
        op_b = {1'b0, cfg.tick_period};
      end
      lmdi_pkg::MS_DIFF_LO: begin
        op_a = diff_r;
        op_b = {1'b0, cfg.inv_period[lmdi_pkg::PER_W-1:0]};
      end
      default: begin
        op_a = diff_r;
        op_b = {1'b0, cfg.inv_period[lmdi_pkg::INV_W-1:lmdi_pkg::PER_W]};
      end
    endcase
  end

  assign new_vel = lmdi_pkg::sat_data({prod_r[lmdi_pkg::PROD_W-1], prod_r}
                                      + lmdi_pkg::sext_lo(lo_r));

  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      clr_r <= in_tuser[0];
      acc_r <= in_tuser[0] ? '0 : lmdi_pkg::clamp_lim(in_tdata, cfg.acc_min, cfg.acc_max);
    end
    if (ctrl.vel_ld) begin
      vel_work_r <= lmdi_pkg::clamp_lim(
        lmdi_pkg::sat_data(lmdi_pkg::sext_data(vel_reg_r)
          + lmdi_pkg::sext_lo(prod_r[lmdi_pkg::PROD_W-1:lmdi_pkg::PER_W])),
        cfg.vel_min, cfg.vel_max);
    end
    if (ctrl.pos_ld) begin
      pos_new_r <= lmdi_pkg::clamp_lim(
        lmdi_pkg::sat_data(lmdi_pkg::sext_data(pos_reg_r)
          + lmdi_pkg::sext_lo(prod_r[lmdi_pkg::PROD_W-1:lmdi_pkg::PER_W])),
        cfg.pos_min, cfg.pos_max);
    end
    if (ctrl.diff_ld) begin
      diff_r <= {pos_new_r[lmdi_pkg::DATA_W-1], pos_new_r}
              - {pos_reg_r[lmdi_pkg::DATA_W-1], pos_reg_r};
    end
    if (ctrl.lo_ld) begin
      lo_r <= prod_r[lmdi_pkg::PROD_W-1:lmdi_pkg::PER_W];
    end
    if (ctrl.commit) begin
      out_pos_r <= clr_r ? '0 : pos_new_r;
      out_vel_r <= clr_r ? '0 : new_vel;
      out_acc_r <= acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_reg_r   <= '0;
      vel_reg_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctrl.commit) begin
        pos_reg_r   <= clr_r ? '0 : pos_new_r;
        vel_reg_r   <= clr_r ? '0 : new_vel;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_acc_r, out_vel_r, out_pos_r};

  `LMDI_ASSERT_IMP(a_commit_no_overwrite, clk, rst_n, ctrl.commit, !out_busy, "result overwritten while stalled")
  `LMDI_ASSERT_NEXT(a_clear_gives_zero, clk, rst_n, ctrl.commit && clr_r, out_tvalid && (out_tdata == '0), "clear result not zero")
  `LMDI_ASSERT_NEXT(a_pos_in_limits, clk, rst_n, ctrl.commit && !clr_r && (cfg.pos_min <= cfg.pos_max), (out_pos_r >= cfg.pos_min) && (out_pos_r <= cfg.pos_max), "position outside limits")
  `LMDI_ASSERT_IMP(a_acc_in_limits, clk, rst_n, ctrl.commit && !clr_r && (cfg.acc_min <= cfg.acc_max), (acc_r >= cfg.acc_min) && (acc_r <= cfg.acc_max), "acceleration outside limits")

endmodule
